// ===== design/sps_pkg.sv =====
`default_nettype none

package sps_pkg;

	// Timer and sizing constants.
	localparam int unsigned TIMER_TICKS_PER_SECOND = 32768;
	localparam int unsigned SOLENOID_COUNT = 4;
	localparam int unsigned CARD_COUNT = 16;

	localparam logic [15:0] TICKS_WORD = 16'(TIMER_TICKS_PER_SECOND);
	localparam logic [7:0] DEFAULT_DIVISOR = 8'd128;

	// One quotient bit per divider step.
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

	// Register map.
	localparam logic [2:0] REG_DIVISOR_ADDR = 3'd0;

	// Solenoid drive patterns.
	localparam logic [SOLENOID_COUNT-1:0] SOL_OFF = 4'b0000;
	localparam logic [SOLENOID_COUNT-1:0] SOL_INSERT_FIRST = 4'b0001;
	localparam logic [SOLENOID_COUNT-1:0] SOL_INSERT_SECOND = 4'b0010;
	localparam logic [SOLENOID_COUNT-1:0] SOL_PULL_FIRST = 4'b0100;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_PULL    = 2'd1,
		CMD_CONNECT = 2'd2,
		CMD_ABORT   = 2'd3
	} sps_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH
	} sps_state_t;

	typedef struct packed {
		logic       start;
		logic [7:0] divisor;
	} sps_div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
	} sps_div_rsp_t;

endpackage

`default_nettype wire

// ===== design/solenoid_pulse_sequencer.sv =====
`default_nettype none

// Solenoid pulse sequencer with a 1-of-16 card selector. Every request on
// the slave stream carries a sample of the free-running 16-bit timer and,
// when s_tuser is high, a command: insert pulses solenoid 1 then solenoid 2
// and rests, pull pulses solenoid 3 and rests, each cycle repeated the
// requested number of times (zero runs once); connect drives one card line
// and the status LED, and abort clears all lines. Each phase lasts the timer
// tick rate divided by the duration_divisor register (APB offset 0, a write
// of zero stores 128, reset 128); a timer value equal to the phase start
// never ends a phase. Commands that arrive while a sequence runs are dropped
// and flagged, while their timer sample is still applied. Every request
// produces exactly one result on the master stream. A request that starts
// an insert or pull first runs the divider, which gives the phase length:
// a restoring divider that resolves one quotient bit per cycle for all 16
// quotient bits. The push state then moves the result into the output
// register, and any other request goes from acceptance straight to the
// push state; the push waits while the output register holds a result not
// yet taken by m_tready. s_tready stays low from acceptance until the
// result has moved into the output register, and the output register
// lets the next request be accepted while a result still waits on
// m_tready.
module solenoid_pulse_sequencer (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         s_tvalid,
	output logic        s_tready,
	// [1:0] command_code, [9:2] parameter_req, [25:10] timer_count, rest zero
	input  wire  [31:0] s_tdata,
	// [0] operation
	input  wire         s_tuser,

	output logic        m_tvalid,
	input  wire         m_tready,
	// [3:0] solenoid_drive, [19:4] card_select, [20] status_led,
	// [25:21] connected_card, [26] busy_res, [27] command_ignored, rest zero
	output logic [31:0] m_tdata,

	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sps_pkg::*;

	// Card number of the set line (i + 1 for line i, 0 for none), ORed over set lines; at most one is ever set.
	function automatic logic [4:0] card_number(input logic [CARD_COUNT-1:0] lines);
		logic [4:0] num;
		num = '0;
		for (int i = 0; i < CARD_COUNT; i++) begin
			if (lines[i]) begin
				num = num | 5'(i + 1);
			end
		end
		return num;
	endfunction

	// Configuration register.
	logic [7:0] divisor_q;
	logic       cfg_write;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_DIVISOR_ADDR);
	assign prdata = (paddr == REG_DIVISOR_ADDR) ? {24'd0, divisor_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DEFAULT_DIVISOR;
		end else if (cfg_write) begin
			divisor_q <= (pwdata[7:0] == 8'd0) ? DEFAULT_DIVISOR : pwdata[7:0];
		end
	end

	// Request fields.
	logic       operation;
	sps_cmd_t   command_code;
	logic [7:0] parameter_req;
	logic [15:0] timer_count;

	assign operation = s_tuser;
	assign command_code = sps_cmd_t'(s_tdata[1:0]);
	assign parameter_req = s_tdata[9:2];
	assign timer_count = s_tdata[25:10];

	// Sequencer state.
	sps_state_t state_q, state_nx;
	logic                  running_q, is_pull_q, act_done_q, rest_done_q;
	logic [7:0]            cycles_done_q, cycles_wanted_q;
	logic [15:0]           phase_start_q, phase_length_q;
	logic [SOLENOID_COUNT-1:0] sol_q;
	logic [CARD_COUNT-1:0] card_q;

	logic                  running_nx, is_pull_nx, act_done_nx, rest_done_nx;
	logic [7:0]            cycles_done_nx, cycles_wanted_nx;
	logic [15:0]           phase_start_nx;
	logic [SOLENOID_COUNT-1:0] sol_nx;
	logic [CARD_COUNT-1:0] card_nx;
	logic                  ignored_nx, start_cmd;

	logic [15:0] fwd_dist;
	logic        expired;

	// Result waiting for the output register, and the output register.
	logic [27:0] res_q;
	logic        out_valid_q;
	logic [27:0] out_data_q;

	logic accept, push_fire;
	sps_div_req_t div_req;
	sps_div_rsp_t div_rsp;

	assign accept = s_tvalid && s_tready;

	// Phase expiry: forward distance from the phase start, one less when the
	// timer has wrapped; an equal timer value never expires.
	always_comb begin
		fwd_dist = timer_count - phase_start_q;
		if (timer_count < phase_start_q) begin
			fwd_dist = fwd_dist - 16'd1;
		end
		expired = (timer_count != phase_start_q) && (fwd_dist > phase_length_q);
	end

	// State update for one request.
	always_comb begin
		running_nx = running_q;
		is_pull_nx = is_pull_q;
		act_done_nx = act_done_q;
		rest_done_nx = rest_done_q;
		cycles_done_nx = cycles_done_q;
		cycles_wanted_nx = cycles_wanted_q;
		phase_start_nx = phase_start_q;
		sol_nx = sol_q;
		card_nx = card_q;
		ignored_nx = 1'b0;
		start_cmd = 1'b0;

		if (operation && running_q) begin
			ignored_nx = 1'b1;
		end else if (operation) begin
			unique case (command_code)
				CMD_INSERT, CMD_PULL: begin
					// The starting sample never ends a phase, so the timer
					// step on this request has no effect.
					start_cmd = 1'b1;
					is_pull_nx = (command_code == CMD_PULL);
					cycles_done_nx = '0;
					cycles_wanted_nx = parameter_req;
					act_done_nx = 1'b0;
					rest_done_nx = 1'b0;
					phase_start_nx = timer_count;
					sol_nx = (command_code == CMD_PULL) ? SOL_PULL_FIRST : SOL_INSERT_FIRST;
					running_nx = 1'b1;
				end
				CMD_CONNECT: begin
					card_nx = '0;
					if (parameter_req >= 8'd1 && parameter_req <= 8'(CARD_COUNT)) begin
						card_nx[4'(parameter_req - 8'd1)] = 1'b1;
					end
				end
				CMD_ABORT: begin
					sol_nx = SOL_OFF;
					card_nx = '0;
				end
				default: begin
				end
			endcase
		end

		if (running_q) begin
			if (expired) begin
				if (!act_done_q) begin
					act_done_nx = 1'b1;
					sol_nx = is_pull_q ? SOL_OFF : SOL_INSERT_SECOND;
					phase_start_nx = timer_count;
				end else if (!rest_done_q) begin
					sol_nx = SOL_OFF;
					rest_done_nx = 1'b1;
				end
			end
			if (act_done_nx && rest_done_nx) begin
				cycles_done_nx = cycles_done_q + 8'd1;
				if (cycles_done_nx < cycles_wanted_q) begin
					act_done_nx = 1'b0;
					rest_done_nx = 1'b0;
					phase_start_nx = timer_count;
					sol_nx = is_pull_q ? SOL_PULL_FIRST : SOL_INSERT_FIRST;
				end else begin
					running_nx = 1'b0;
				end
			end
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = start_cmd ? ST_DIV : ST_PUSH;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_nx = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (push_fire) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		div_req.start = (state_q == ST_IDLE) && s_tvalid && start_cmd;
		div_req.divisor = divisor_q;
		push_fire = (state_q == ST_PUSH) && (!out_valid_q || m_tready);
	end

	sps_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			running_q <= 1'b0;
			is_pull_q <= 1'b0;
			act_done_q <= 1'b0;
			rest_done_q <= 1'b0;
			cycles_done_q <= '0;
			cycles_wanted_q <= '0;
			phase_start_q <= '0;
			phase_length_q <= '0;
			sol_q <= SOL_OFF;
			card_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				running_q <= running_nx;
				is_pull_q <= is_pull_nx;
				act_done_q <= act_done_nx;
				rest_done_q <= rest_done_nx;
				cycles_done_q <= cycles_done_nx;
				cycles_wanted_q <= cycles_wanted_nx;
				phase_start_q <= phase_start_nx;
				sol_q <= sol_nx;
				card_q <= card_nx;
			end
			if (state_q == ST_DIV && div_rsp.done) begin
				phase_length_q <= div_rsp.quotient;
			end
			if (push_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= {ignored_nx, running_nx, card_number(card_nx), (card_nx != '0),
				card_nx, sol_nx};
		end
		if (push_fire) begin
			out_data_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'd0, out_data_q};

endmodule

`default_nettype wire

// ===== design/sps_divider.sv =====
`default_nettype none

// Restoring divider: the tick rate divided by the divisor, one quotient bit
// per cycle. The response is valid in the cycle that done is high.
module sps_divider (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire sps_pkg::sps_div_req_t div_req,
	output sps_pkg::sps_div_rsp_t      div_rsp
);
	import sps_pkg::*;

	logic                  busy_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [7:0]            divisor_q;
	logic [7:0]            rem_q;
	logic [15:0]           quo_q;

	logic [8:0] trial;
	logic       fits;
	logic [7:0] rem_next;

	always_comb begin
		trial = {rem_q, quo_q[15]};
		fits = (trial >= {1'b0, divisor_q});
		rem_next = fits ? 8'(trial - {1'b0, divisor_q}) : trial[7:0];
	end

	assign div_rsp.done = busy_q && (step_q == DIV_STEP_W'(DIV_STEPS - 1));
	assign div_rsp.quotient = {quo_q[14:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (div_req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (div_rsp.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_req.start) begin
			divisor_q <= div_req.divisor;
			rem_q <= '0;
			quo_q <= TICKS_WORD;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[14:0], fits};
		end
	end

endmodule

`default_nettype wire

// ===== design/sps_checker.sv =====
`default_nettype none

// Port-level checks for the solenoid pulse sequencer.
module sps_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata
);

	// One request in flight: the slave side closes right after acceptance.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while the previous one is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_card_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[19:4]) && $onehot0(m_tdata[3:0]))
		else $error("more than one card or solenoid line driven");

	a_led_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[20] == (m_tdata[19:4] != 16'd0))
			&& ((m_tdata[25:21] == 5'd0) == (m_tdata[19:4] == 16'd0)))
		else $error("status LED or card number disagrees with card lines");

endmodule

bind solenoid_pulse_sequencer sps_checker u_sps_checker (.*);

`default_nettype wire
